[src/l2qa_pkg.sv]
// Package for the quadratic log2 approximation block.
// Shared constants, stage payload types and a helper function; no dependencies.
package l2qa_pkg;

    localparam logic [63:0] ONE_PATTERN = 64'h3FF0_0000_0000_0000;
    localparam int          FRAC_W      = 52;
    localparam int          HALF_W      = 26;
    localparam int          SQ_SHIFT    = 25;
    localparam int          EXP_BIAS    = 1023;
    localparam int          SCALE_SHIFT = 52;

    // ceil(2^56/3): q = (n * RECIP3) >> 56 is exact floor(n/3) for n < 2^54
    localparam logic [54:0] RECIP3      = 55'h55_5555_5555_5556;

    // after multiply stage
    typedef struct packed {
        logic [63:0] d;
        logic [51:0] f;
        logic [51:0] hh;
        logic [51:0] hl;
    } l2qa_mul_t;

    // after square / difference stage
    typedef struct packed {
        logic [63:0] d;
        logic        neg;
        logic [52:0] diff;
    } l2qa_diff_t;

    // after reciprocal partial products: diff split 27/26, RECIP3 split 27/28
    typedef struct packed {
        logic [63:0] d;
        logic        neg;
        logic [53:0] pp_hh;
        logic [54:0] pp_hl;
        logic [52:0] pp_lh;
        logic [53:0] pp_ll;
    } l2qa_part_t;

    // after divide-by-3 stage
    typedef struct packed {
        logic [63:0] sum;
    } l2qa_sum_t;

    // after leading-one stage
    typedef struct packed {
        logic        sign;
        logic [63:0] mag;
        logic [5:0]  msb;
        logic        zero;
    } l2qa_norm_t;

    // position of the most significant set bit
    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

[src/l2qa_arith.sv]
// Arithmetic front end: pattern subtract, half products, square, divide by three.
// Four register stages with stall; depends on l2qa_pkg.
module l2qa_arith
    import l2qa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] x_bits,
    output logic        out_valid,
    output l2qa_sum_t   out_data
);
    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    l2qa_mul_t  s1_reg, s1_next;
    l2qa_diff_t s2_reg, s2_next;
    l2qa_part_t s3_reg, s3_next;
    l2qa_sum_t  s4_reg, s4_next;

    always_comb
    begin
        logic [25:0] hi, lo;
        s1_next.d = x_bits - ONE_PATTERN;
        s1_next.f = s1_next.d[51:0];
        hi = s1_next.f[51:26];
        lo = s1_next.f[25:0];
        s1_next.hh = hi * hi;
        s1_next.hl = hi * lo;
    end

    always_comb
    begin
        logic [52:0] sq;
        sq = {1'b0, s1_reg.hh} + {26'b0, s1_reg.hl[51:SQ_SHIFT]};
        s2_next.d = s1_reg.d;
        s2_next.neg = ({1'b0, s1_reg.f} < sq);
        s2_next.diff = s2_next.neg ? (sq - {1'b0, s1_reg.f}) : ({1'b0, s1_reg.f} - sq);
    end

    // reciprocal multiply split into four partial products
    always_comb
    begin
        logic [26:0] dh;
        logic [25:0] dl;
        logic [26:0] rh;
        logic [27:0] rl;
        dh = s2_reg.diff[52:26];
        dl = s2_reg.diff[25:0];
        rh = RECIP3[54:28];
        rl = RECIP3[27:0];
        s3_next.d     = s2_reg.d;
        s3_next.neg   = s2_reg.neg;
        s3_next.pp_hh = dh * rh;
        s3_next.pp_hl = dh * rl;
        s3_next.pp_lh = dl * rh;
        s3_next.pp_ll = dl * rl;
    end

    always_comb
    begin
        logic [108:0] prod;
        logic [63:0]  q;
        prod = ({55'b0, s3_reg.pp_hh} << 54) + ({54'b0, s3_reg.pp_hl} << 26)
             + ({56'b0, s3_reg.pp_lh} << 28) + {55'b0, s3_reg.pp_ll};
        q = {11'b0, prod[108:56]};
        s4_next.sum = s3_reg.neg ? (s3_reg.d - q) : (s3_reg.d + q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = s4_reg;
endmodule

[src/l2qa_conv.sv]
// Integer to scaled binary64 conversion: magnitude and leading one, then round/pack.
// Two register stages with stall; depends on l2qa_pkg.
module l2qa_conv
    import l2qa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  l2qa_sum_t   in_data,
    output logic        out_valid,
    output logic [63:0] out_bits
);
    logic       v4_reg, v5_reg;
    l2qa_norm_t s4_reg, s4_next;
    logic [63:0] res5_reg, res5_next;

    always_comb
    begin
        s4_next.sign = in_data.sum[63];
        s4_next.mag  = s4_next.sign ? (64'd0 - in_data.sum) : in_data.sum;
        s4_next.msb  = lead_one(s4_next.mag);
        s4_next.zero = (s4_next.mag == 64'd0);
    end

    always_comb
    begin
        logic [63:0] aligned, rem, half;
        logic [53:0] mant;
        logic [10:0] biased;
        logic [5:0]  r;
        biased = 11'(int'(s4_reg.msb) - SCALE_SHIFT + EXP_BIAS);
        aligned = '0;
        rem = '0;
        half = '0;
        if (s4_reg.msb <= 6'd52)
        begin
            r = 6'd52 - s4_reg.msb;
            mant = {1'b0, 53'(s4_reg.mag << r)};
        end
        else
        begin
            r = s4_reg.msb - 6'd52;
            aligned = s4_reg.mag >> r;
            rem  = s4_reg.mag & ((64'd1 << r) - 64'd1);
            half = 64'd1 << (r - 6'd1);
            mant = {1'b0, aligned[52:0]};
            if (rem > half || (rem == half && aligned[0]))
            begin
                mant = mant + 54'd1;
            end
            if (mant[53])
            begin
                mant = mant >> 1;
                biased = biased + 11'd1;
            end
        end
        res5_next = s4_reg.zero ? 64'd0 : {s4_reg.sign, biased, mant[51:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg   <= s4_next;
            res5_reg <= res5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_bits  = res5_reg;
endmodule

[src/log2_bit_pattern_quadratic_approx.sv]
// Top level of the quadratic log2 approximation on binary64 bit patterns.
// Uses l2qa_arith and l2qa_conv; depends on l2qa_pkg.
//
// Usage:
//   s_axis carries one 64-bit input word (x_bits) per beat; m_axis returns
//   one 64-bit word (log2_bits) per accepted input, in order.
//   Throughput: one word per cycle when the output is not stalled.
//   The pipeline is six register stages: subtract and 26x26 half products,
//   square and difference, partial products of the reciprocal-of-three
//   multiply, quotient sum and signed add, magnitude and leading one,
//   round and pack.
//   The whole pipeline advances together; when m_axis_tready is low and the
//   output holds a word, every stage holds and s_axis_tready drops, so no
//   word is lost or repeated. Only a bubble at the output is squeezed out:
//   every stage advances whenever the output is empty or being taken.
//   Reset clears all valid bits; payload registers are left as they are.
//   Non-positive, infinite and NaN inputs are not flagged.
module log2_bit_pattern_quadratic_approx
    import l2qa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] x_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] log2_bits
);
    logic      en;
    logic      a_valid;
    l2qa_sum_t a_data;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    l2qa_arith u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .x_bits   (s_axis_tdata),
        .out_valid(a_valid),
        .out_data (a_data)
    );

    l2qa_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (a_valid),
        .in_data  (a_data),
        .out_valid(m_axis_tvalid),
        .out_bits (m_axis_tdata)
    );
endmodule

[src/l2qa_checker.sv]
// Port-level checker for the log2 approximation block, with its bind.
// Depends only on the top level's ports.
module l2qa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    // ready follows only the output side
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

    // an accepted word arrives at the output while the output stays free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready
         ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
         ##1 m_axis_tready)
        |=> m_axis_tvalid)
        else $error("word missing after pipeline latency");
endmodule

bind log2_bit_pattern_quadratic_approx l2qa_checker u_l2qa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
